// ----- sv/assert_macros.svh -----
// Shared assertion macros: clocked on clk_i, quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define PSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define PSA_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

// ----- sv/psa_pkg.sv -----
`default_nettype none
package psa_pkg;

  localparam int FREE_DEPTH  = 1024;
  localparam int MAX_EXTEND  = 64;
  localparam int QUEUE_DEPTH = 2;

  localparam int PTR_W   = $clog2(FREE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(FREE_DEPTH);
  localparam int EXT_W   = $clog2(MAX_EXTEND + 1);
  localparam int CMP_W   = (PTR_W > EXT_W) ? PTR_W : EXT_W;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W    = 2;
  localparam int PS_W    = 11;
  localparam int PAGE_W  = 20;
  localparam int LEN_W   = 20;
  localparam int LSLOT_W = 31;
  localparam int SLOT_W  = 30;
  localparam int POS_W   = 24;
  localparam int PAGES_W = 11;
  localparam int ERR_W   = 2;

  localparam int DIV_STEPS = LEN_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam int IN_FIELDS_W  = PAGE_W + 2 * LEN_W + LSLOT_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_W + POS_W + PAGES_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [PS_W-1:0] PS_RESET = PS_W'(128);

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_REQ   = 2'd1;
  localparam logic [OP_W-1:0] OP_BATCH = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_LEN      = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNDERRUN = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_REQ,
    CMD_BATCH,
    CMD_BADLEN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [PAGE_W-1:0]    page;
    logic [LEN_W-1:0]     prior_len;
    logic [EXT_W-1:0]     ext;
    logic [LSLOT_W-1:0]   last_slot;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [LEN_W-1:0]  dividend;
    logic [PS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [LEN_W-1:0]  quot;
    logic [PS_W-1:0]   rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_DIV1,
    BK_PREP2,
    BK_DIV2,
    BK_CHECK,
    BK_EMIT_A,
    BK_FETCH,
    BK_MUL,
    BK_EMIT_B,
    BK_ERR
  } back_state_e;

endpackage
`default_nettype wire

// ----- sv/psa_front.sv -----
`default_nettype none
module psa_front import psa_pkg::*; (
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [IN_DATA_W-1:0] data_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output cmd_t                 cmd_o
);

  logic [LEN_W-1:0] prior_len;
  logic [LEN_W-1:0] new_len;
  logic [LEN_W-1:0] diff;
  logic             bad_len;
  logic             keep;

  always_comb begin
    prior_len = data_i[PAGE_W +: LEN_W];
    new_len   = data_i[PAGE_W + LEN_W +: LEN_W];
    diff      = new_len - prior_len;
    bad_len   = (new_len < prior_len) || (diff > LEN_W'(MAX_EXTEND));

    cmd_o.page      = data_i[PAGE_W-1:0];
    cmd_o.prior_len = prior_len;
    cmd_o.ext       = diff[EXT_W-1:0];
    cmd_o.last_slot = data_i[PAGE_W + 2 * LEN_W +: LSLOT_W];
    keep            = 1'b1;

    case (op_i)
      OP_PUSH:  cmd_o.kind = CMD_PUSH;
      OP_REQ:   cmd_o.kind = bad_len ? CMD_BADLEN : CMD_REQ;
      OP_BATCH: cmd_o.kind = CMD_BATCH;
      default: begin
        // unused selector: taken and dropped
        cmd_o.kind = CMD_PUSH;
        keep       = 1'b0;
      end
    endcase

    ready_o = !q_full_i;
    push_o  = valid_i && !q_full_i && keep;
  end

endmodule
`default_nettype wire

// ----- sv/psa_queue.sv -----
`default_nettype none
`include "assert_macros.svh"
module psa_queue import psa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_pop;

  always_comb begin
    full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
    empty_o = (cnt_q == '0);
    head_o  = mem_q[rd_q];
    do_pop  = pop_i && !empty_o;
    wr_d    = wr_q;
    rd_d    = rd_q;
    cnt_d   = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  `PSA_ASSERT(a_q_no_overflow, full_o |-> !push_i, "command queue written while full")
  `PSA_ASSERT(a_q_no_underflow, empty_o |-> !pop_i, "command queue read while empty")

endmodule
`default_nettype wire

// ----- sv/psa_div.sv -----
`default_nettype none
`include "assert_macros.svh"
module psa_div import psa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [PS_W-1:0]   rem_q, rem_d;
  logic [LEN_W-1:0]  quo_q, quo_d;
  logic [PS_W-1:0]   dsr_q, dsr_d;
  logic [PS_W:0]     trial;
  logic [PS_W:0]     trial_sub;
  logic              fits;

  // restoring divider, one quotient bit per cycle
  always_comb begin
    trial     = {rem_q, quo_q[LEN_W-1]};
    trial_sub = trial - {1'b0, dsr_q};
    fits      = (trial >= {1'b0, dsr_q});
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dsr_d     = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(DIV_STEPS);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? trial_sub[PS_W-1:0] : trial[PS_W-1:0];
      quo_d = {quo_q[LEN_W-2:0], fits};
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    rsp_o.done = done_q;
    rsp_o.quot = quo_q;
    rsp_o.rem  = rem_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  `PSA_ASSERT(a_div_no_restart, req_i.start |-> !busy_q, "divider started while busy")

endmodule
`default_nettype wire

// ----- sv/psa_ram.sv -----
`default_nettype none
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- sv/psa_back.sv -----
`default_nettype none
`include "assert_macros.svh"
module psa_back import psa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [PS_W-1:0]       ps_i,        // page size, never zero
  input  logic                  q_empty_i,
  input  cmd_t                  q_head_i,
  output logic                  q_pop_o,
  output div_req_t              div_req_o,
  input  div_rsp_t              div_rsp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o,
  output logic [ERR_W-1:0]      out_err_o
);

  back_state_e        state_q, state_d;
  logic [PTR_W-1:0]   wp_q, wp_d;
  logic [PTR_W-1:0]   rp_q, rp_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [POS_W-1:0]   off_q, off_d;
  cmd_t               cur_q, cur_d;
  logic [EXT_W-1:0]   p1_q, p1_d;
  logic [EXT_W-1:0]   left_q, left_d;
  logic [EXT_W-1:0]   need_q, need_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [PS_W-1:0]    j_q, j_d;
  logic [ERR_W-1:0]   err_q, err_d;

  logic               ov_q, ov_d;
  logic [SLOT_W-1:0]  o_slot_q, o_slot_d;
  logic [POS_W-1:0]   o_pos_q, o_pos_d;
  logic [PAGES_W-1:0] o_pages_q, o_pages_d;
  logic               o_last_q, o_last_d;
  logic [ERR_W-1:0]   o_err_q, o_err_d;

  logic               ram_we;
  logic               ram_re;
  logic [PAGE_W-1:0]  ram_rdata;
  logic               can_load;
  logic [PS_W-1:0]    room;
  logic [PS_W:0]      ceil_sum;
  logic [PAGE_W+PS_W-1:0] prod;

  psa_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (FREE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q[ADDR_W-1:0]),
    .wdata_i (q_head_i.page),
    .re_i    (ram_re),
    .raddr_i (rd_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    can_load = !ov_q || out_ready_i;
    // free tokens left in the partly used page
    room     = (div_rsp_i.rem == '0) ? '0 : ps_i - div_rsp_i.rem;
    ceil_sum = (PS_W + 1)'(cur_q.ext - p1_q) + (PS_W + 1)'(ps_i) - (PS_W + 1)'(1);
    prod     = (PAGE_W + PS_W)'(ram_rdata) * (PAGE_W + PS_W)'(ps_i);

    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    rd_d      = rd_q;
    off_d     = off_q;
    cur_d     = cur_q;
    p1_d      = p1_q;
    left_d    = left_q;
    need_d    = need_q;
    slot_d    = slot_q;
    pos_d     = pos_q;
    j_d       = j_q;
    err_d     = err_q;
    ov_d      = ov_q && !out_ready_i;
    o_slot_d  = o_slot_q;
    o_pos_d   = o_pos_q;
    o_pages_d = o_pages_q;
    o_last_d  = o_last_q;
    o_err_d   = o_err_q;

    q_pop_o            = 1'b0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = q_head_i.prior_len;
    div_req_o.divisor  = ps_i;

    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_head_i;
          case (q_head_i.kind)
            CMD_PUSH: begin
              if (wp_q < PTR_W'(FREE_DEPTH)) begin
                ram_we = 1'b1;
                wp_d   = wp_q + 1'b1;
              end
            end
            CMD_BATCH: begin
              wp_d  = '0;
              rp_d  = '0;
              off_d = '0;
            end
            CMD_BADLEN: begin
              err_d   = ERR_LEN;
              state_d = BK_ERR;
            end
            CMD_REQ: begin
              if (q_head_i.ext != '0) begin
                div_req_o.start = 1'b1;
                state_d         = BK_DIV1;
              end
            end
            default: ;
          endcase
        end
      end
      BK_DIV1: begin
        if (div_rsp_i.done) begin
          p1_d    = (PS_W'(cur_q.ext) < room) ? cur_q.ext : room[EXT_W-1:0];
          state_d = BK_PREP2;
        end
      end
      BK_PREP2: begin
        // fresh pages needed: ceil of the leftover tokens over the page size
        div_req_o.start    = 1'b1;
        div_req_o.dividend = LEN_W'(ceil_sum);
        state_d            = BK_DIV2;
      end
      BK_DIV2: begin
        if (div_rsp_i.done) begin
          need_d  = div_rsp_i.quot[EXT_W-1:0];
          state_d = BK_CHECK;
        end
      end
      BK_CHECK: begin
        if (CMP_W'(need_q) > CMP_W'(wp_q - rp_q)) begin
          err_d   = ERR_UNDERRUN;
          state_d = BK_ERR;
        end else begin
          rp_d    = rp_q + PTR_W'(need_q);
          rd_d    = rp_q;
          off_d   = off_q + POS_W'(cur_q.ext);
          slot_d  = SLOT_W'(cur_q.last_slot + LSLOT_W'(1));
          pos_d   = off_q;
          left_d  = cur_q.ext;
          state_d = (p1_q != '0) ? BK_EMIT_A : BK_FETCH;
        end
      end
      BK_EMIT_A: begin
        if (can_load) begin
          ov_d      = 1'b1;
          o_slot_d  = slot_q;
          o_pos_d   = pos_q;
          o_pages_d = PAGES_W'(rp_q);
          o_last_d  = (left_q == EXT_W'(1));
          o_err_d   = ERR_NONE;
          slot_d    = slot_q + 1'b1;
          pos_d     = pos_q + 1'b1;
          left_d    = left_q - 1'b1;
          p1_d      = p1_q - 1'b1;
          if (p1_q == EXT_W'(1)) begin
            state_d = (left_q == EXT_W'(1)) ? BK_IDLE : BK_FETCH;
          end
        end
      end
      BK_FETCH: begin
        ram_re  = 1'b1;
        rd_d    = rd_q + 1'b1;
        state_d = BK_MUL;
      end
      BK_MUL: begin
        slot_d  = prod[SLOT_W-1:0];
        j_d     = '0;
        state_d = BK_EMIT_B;
      end
      BK_EMIT_B: begin
        if (can_load) begin
          ov_d      = 1'b1;
          o_slot_d  = slot_q;
          o_pos_d   = pos_q;
          o_pages_d = PAGES_W'(rp_q);
          o_last_d  = (left_q == EXT_W'(1));
          o_err_d   = ERR_NONE;
          slot_d    = slot_q + 1'b1;
          pos_d     = pos_q + 1'b1;
          left_d    = left_q - 1'b1;
          j_d       = j_q + 1'b1;
          if (left_q == EXT_W'(1)) begin
            state_d = BK_IDLE;
          end else if (j_q == ps_i - PS_W'(1)) begin
            state_d = BK_FETCH;
          end
        end
      end
      BK_ERR: begin
        if (can_load) begin
          ov_d      = 1'b1;
          o_slot_d  = '0;
          o_pos_d   = off_q;
          o_pages_d = PAGES_W'(rp_q);
          o_last_d  = 1'b1;
          o_err_d   = err_q;
          state_d   = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      off_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      off_q   <= off_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q      <= rd_d;
    cur_q     <= cur_d;
    p1_q      <= p1_d;
    left_q    <= left_d;
    need_q    <= need_d;
    slot_q    <= slot_d;
    pos_q     <= pos_d;
    j_q       <= j_d;
    err_q     <= err_d;
    o_slot_q  <= o_slot_d;
    o_pos_q   <= o_pos_d;
    o_pages_q <= o_pages_d;
    o_last_q  <= o_last_d;
    o_err_q   <= o_err_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), o_pages_q, o_pos_q, o_slot_q};
  assign out_last_o  = o_last_q;
  assign out_err_o   = o_err_q;

  `PSA_ASSERT(a_rd_not_past_wr, rp_q <= wp_q, "page read pointer passed write pointer")
  `PSA_ASSERT(a_err_is_last, ov_q && (o_err_q != ERR_NONE) |-> o_last_q, "error item not last")

endmodule
`default_nettype wire

// ----- sv/paged_slot_allocator_unit.sv -----
// Paged slot allocator. Push and new-batch items are handled in the idle state.
// An allocation request with a nonzero extension runs a 20-step serial divider
// twice (page offset of prior_len, then the count of fresh pages); results then
// stream at one per cycle while the output is not stalled, and each fresh page
// first takes a store read, then a page times page size multiply. A length or
// underrun error gives one item with tlast set. A two-entry command queue lets
// the input side keep accepting while the back end works, and an output register
// lets the next command start while a result waits. A page size of 0 is treated
// as 1; write it only while the block is idle.
`default_nettype none
module paged_slot_allocator_unit import psa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // free_page, prior_len, new_len, last_slot, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // slot, out_position, pages_used, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  // error
  output logic [ERR_W-1:0]      m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [PS_W-1:0]       cfg_data_i
);

  logic [PS_W-1:0] ps_q, ps_d;
  logic [PS_W-1:0] ps_eff;
  logic            q_push;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  cmd_t            push_cmd;
  cmd_t            head_cmd;
  div_req_t        div_req;
  div_rsp_t        div_rsp;

  assign cfg_ready_o = 1'b1;
  assign ps_d        = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : ps_q;
  assign ps_eff      = (ps_q == '0) ? PS_W'(1) : ps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q <= PS_RESET;
    end else begin
      ps_q <= ps_d;
    end
  end

  psa_front u_front (
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .op_i     (s_axis_tuser),
    .data_i   (s_axis_tdata),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (push_cmd)
  );

  psa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (head_cmd)
  );

  psa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  psa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ps_i        (ps_eff),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none
module tb_top;
  import psa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // back end may still be busy on items that yield no result
  localparam int QUIET_CYCLES = 300;
  localparam int RAND_ITEMS = 230;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [POS_W-1:0]   position;
    logic [PAGES_W-1:0] pages;
    logic               last;
    logic [ERR_W-1:0]   err;
  } slot_rec_t;

  // Mirrors the allocator state and queues the slots each item should produce.
  class slot_tracker;
    bit [PS_W-1:0]   pg_tokens = PS_RESET;
    bit [PAGE_W-1:0] free_pages [FREE_DEPTH];
    int unsigned     wr_ptr;
    int unsigned     rd_ptr;
    bit [POS_W-1:0]  out_ofs;
    slot_rec_t       due [$];
    int              faults;

    function void expect_slot(bit [31:0] slot, bit [31:0] pos, bit [31:0] pages,
                              bit last, bit [ERR_W-1:0] err);
      slot_rec_t r;
      r.slot     = slot[SLOT_W-1:0];
      r.position = pos[POS_W-1:0];
      r.pages    = pages[PAGES_W-1:0];
      r.last     = last;
      r.err      = err;
      due.push_back(r);
    endfunction

    function void predict_request(bit [31:0] p, bit [31:0] n, bit [31:0] ls);
      bit [31:0] ps, ext, need, base, used, pos0, pbound, part1, part2, fl, page, i, k, pg;
      ps   = (pg_tokens == 0) ? 32'd1 : 32'(pg_tokens);
      pos0 = 32'(out_ofs);
      k    = 0;
      if (n < p || n - p > MAX_EXTEND) begin
        expect_slot(0, pos0, rd_ptr, 1'b1, ERR_LEN);
        return;
      end
      ext  = n - p;
      need = (n + ps - 1) / ps - (p + ps - 1) / ps;
      if (need > wr_ptr - rd_ptr) begin
        expect_slot(0, pos0, rd_ptr, 1'b1, ERR_UNDERRUN);
        return;
      end
      if (ext == 0)
        return;
      base    = rd_ptr;
      rd_ptr += need;
      used    = rd_ptr;
      out_ofs = out_ofs + POS_W'(ext);
      // rest of the partly used page after last_slot
      pbound = (p + ps - 1) / ps * ps;
      part1  = ((n < pbound) ? n : pbound) - p;
      for (i = 0; i < part1; i++, k++)
        expect_slot(ls + 1 + i, pos0 + k, used, 1'b0, ERR_NONE);
      if (p + part1 < n) begin
        fl    = n / ps * ps;
        part2 = (fl > pbound) ? fl - pbound : 0;
        for (pg = 0; pg < part2 / ps; pg++) begin
          page = 32'(free_pages[base + pg]);
          for (i = 0; i < ps; i++, k++)
            expect_slot(page * ps + i, pos0 + k, used, 1'b0, ERR_NONE);
        end
        // head of one more page for what is left
        if (p + part1 + part2 < n) begin
          page = 32'(free_pages[base + need - 1]);
          for (i = 0; i < n - fl; i++, k++)
            expect_slot(page * ps + i, pos0 + k, used, 1'b0, ERR_NONE);
        end
      end
      due[due.size() - 1].last = 1'b1;
    endfunction

    function void note_item(logic [OP_W-1:0] op, bit [PAGE_W-1:0] page,
                            bit [LEN_W-1:0] p, bit [LEN_W-1:0] n, bit [LSLOT_W-1:0] ls);
      case (op)
        OP_PUSH: begin
          if (wr_ptr < FREE_DEPTH) begin
            free_pages[wr_ptr] = page;
            wr_ptr++;
          end
        end
        OP_BATCH: begin
          wr_ptr  = 0;
          rd_ptr  = 0;
          out_ofs = '0;
        end
        OP_REQ: predict_request(32'(p), 32'(n), 32'(ls));
        default: ;
      endcase
    endfunction

    function void report(string what, slot_rec_t exp, slot_rec_t got);
      faults++;
      if (faults <= 10)
        $display("%s: expected slot=%h pos=%0d pages=%0d last=%b err=%0d, got slot=%h pos=%0d pages=%0d last=%b err=%0d",
                 what, exp.slot, exp.position, exp.pages, exp.last, exp.err,
                 got.slot, got.position, got.pages, got.last, got.err);
    endfunction

    function void check_result(slot_rec_t got);
      slot_rec_t exp;
      if (due.size() == 0) begin
        report("item with none pending", '0, got);
        return;
      end
      exp = due.pop_front();
      if (got.slot !== exp.slot || got.position !== exp.position || got.pages !== exp.pages ||
          got.last !== exp.last || got.err !== exp.err)
        report("item mismatch", exp, got);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic [ERR_W-1:0]      m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [PS_W-1:0]       cfg_data = '0;

  slot_tracker tracker = new();
  int unsigned cycles = 0;
  int          items_sent = 0;
  int          src_quiet = 0;
  int          sink_quiet = 0;

  paged_slot_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // random wait before an item, with occasional runs of back-to-back items
  function automatic int pick_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic bit [PAGE_W-1:0] rand_page();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PAGE_W'($urandom);
    endcase
  endfunction

  // all tasks start and end on a rising edge
  task automatic send_item(input logic [OP_W-1:0] op, input bit [PAGE_W-1:0] page,
                           input bit [LEN_W-1:0] p, input bit [LEN_W-1:0] n,
                           input bit [LSLOT_W-1:0] ls);
    int gap;
    gap = pick_wait(src_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({ls, n, p, page});
    s_tuser  <= op;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    tracker.note_item(op, page, p, n, ls);
    if (op != OP_NONE)
      items_sent++;
  endtask

  task automatic push_pages(input int count, input bit [PAGE_W-1:0] page = '0,
                            input bit fixed = 1'b0);
    repeat (count)
      send_item(OP_PUSH, fixed ? page : rand_page(), LEN_W'($urandom), LEN_W'($urandom),
                LSLOT_W'($urandom));
  endtask

  task automatic new_batch();
    send_item(OP_BATCH, PAGE_W'($urandom), LEN_W'($urandom), LEN_W'($urandom),
              LSLOT_W'($urandom));
  endtask

  task automatic request(input bit [LEN_W-1:0] p, input bit [LEN_W-1:0] n,
                         input bit [LSLOT_W-1:0] ls);
    send_item(OP_REQ, PAGE_W'($urandom), p, n, ls);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.due.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pg_tokens(input bit [PS_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
    tracker.pg_tokens = value;
  endtask

  task automatic random_request();
    int unsigned ps, p, n, ext;
    bit [LSLOT_W-1:0] ls;
    ps = (tracker.pg_tokens == 0) ? 1 : tracker.pg_tokens;
    case ($urandom_range(0, 19))
      0: begin
        p = $urandom_range(0, 20'hFFFFF);
        n = p;
      end
      1: begin
        p = $urandom_range(1, 20'hFFFFF);
        n = $urandom_range(0, p - 1);
      end
      2: begin
        p = $urandom_range(0, 20'hFFFFF - MAX_EXTEND - 1);
        n = $urandom_range(p + MAX_EXTEND + 1, 20'hFFFFF);
      end
      default: begin
        ext = ($urandom_range(0, 4) == 0) ? MAX_EXTEND : $urandom_range(1, MAX_EXTEND);
        case ($urandom_range(0, 3))
          0: p = 0;
          1: p = ($urandom_range(0, 20'hFFFBF) / ps) * ps;
          2: p = ($urandom_range(0, 20'hFFFBF) / ps) * ps + $urandom_range(0, ps - 1);
          default: p = $urandom_range(0, 20'hFFFBF);
        endcase
        if (p > 20'hFFFFF - ext)
          p = 20'hFFFFF - ext;
        n = p + ext;
      end
    endcase
    case ($urandom_range(0, 9))
      0: ls = '1;
      1: ls = LSLOT_W'(32'h3FFF_FFFF - $urandom_range(0, 63));
      default: ls = LSLOT_W'($urandom_range(0, 32'h3FFF_FFFF));
    endcase
    request(LEN_W'(p), LEN_W'(n), ls);
  endtask

  initial begin : drain_results
    int        stall;
    slot_rec_t got;
    forever begin
      stall = pick_wait(sink_quiet);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(negedge clk_i);
      while (!m_axis_tvalid) @(negedge clk_i);
      got.slot     = m_axis_tdata[SLOT_W-1:0];
      got.position = m_axis_tdata[SLOT_W +: POS_W];
      got.pages    = m_axis_tdata[SLOT_W + POS_W +: PAGES_W];
      got.last     = m_axis_tlast;
      got.err      = m_axis_tuser;
      @(posedge clk_i);
      tracker.check_result(got);
    end
  end

  initial begin : stimulus
    int unsigned ps;
    int          nreq;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: lengths at the edges, slot wrap, underrun, unused op
    write_pg_tokens(PS_W'(4));
    new_batch();
    push_pages(1, '1, 1'b1);
    push_pages(1, '0, 1'b1);
    push_pages(2);
    request(20'd0, 20'd0, '0);
    request(20'd2, 20'd1, '0);
    request(20'd0, 20'd65, '0);
    request(20'hFFFFF, 20'd0, '0);
    request(20'd1, 20'd14, '1);
    request(20'd3, 20'd5, 31'h3FFF_FFFF);
    request(20'd8, 20'd9, 31'd77);
    send_item(OP_NONE, '1, '1, '1, '1);
    request(20'hFFFFE, 20'hFFFFF, 31'h1234_5678);
    new_batch();
    request(20'd0, 20'd1, '0);

    // a zero page size counts as one token per page
    write_pg_tokens(PS_W'(0));
    new_batch();
    push_pages(1, '1, 1'b1);
    push_pages(1, 20'd1, 1'b1);
    request(20'd0, 20'd2, 31'd5);

    write_pg_tokens(PS_W'(1024));
    new_batch();
    push_pages(1, '1, 1'b1);
    request(20'd0, 20'd64, '0);

    write_pg_tokens(PS_W'(1023));
    new_batch();
    push_pages(1);
    request(20'd1000, 20'd1064, 31'd9);

    // random batches: pages pushed ahead of most requests keep the store fed
    while (items_sent < RAND_ITEMS) begin
      case ($urandom_range(0, 9))
        0: ps = $urandom_range(1, 1024);
        1: ps = 1;
        2: ps = 0;
        default: ps = $urandom_range(2, 32);
      endcase
      write_pg_tokens(PS_W'(ps));
      if (ps == 0)
        ps = 1;
      new_batch();
      push_pages($urandom_range(1, 8));
      nreq = $urandom_range(4, 12);
      repeat (nreq) begin
        if (items_sent < RAND_ITEMS) begin
          if ($urandom_range(0, 3) != 0)
            push_pages($urandom_range(0, MAX_EXTEND / ps + 1));
          if ($urandom_range(0, 29) == 0)
            send_item(OP_NONE, PAGE_W'($urandom), LEN_W'($urandom), LEN_W'($urandom),
                      LSLOT_W'($urandom));
          if ($urandom_range(0, 39) == 0)
            new_batch();
          random_request();
        end
      end
    end

    // fill the store, then drain it until a request runs short of pages
    write_pg_tokens(PS_W'(1));
    new_batch();
    push_pages(2 * MAX_EXTEND + 6);
    repeat (3)
      request(LEN_W'(1000), LEN_W'(1000 + MAX_EXTEND),
              LSLOT_W'($urandom_range(0, 32'h3FFF_FFFF)));

    settle();
    if (tracker.faults == 0 && tracker.due.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
